[rtl/aprcm_pkg.sv]
// ----------------------------------------------------------------------------
// aprcm_pkg
// Shared constants and register codes for the atlas piece clip and map block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aprcm_pkg;

  // width of one request field
  localparam int REQ_BITS = 16;
  // signed width that holds request edges and mapped crop edges
  localparam int SW = 18;
  // configuration port
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int SIZE_REG_BITS = 24;

  // register indexes
  typedef enum logic [2:0] {
    REG_PIECE_X      = 3'd0,
    REG_PIECE_Y      = 3'd1,
    REG_PIECE_WIDTH  = 3'd2,
    REG_PIECE_HEIGHT = 3'd3,
    REG_CROP_X       = 3'd4,
    REG_CROP_Y       = 3'd5,
    REG_CROP_SIZE    = 3'd6,
    REG_ATLAS_SIZE   = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

[rtl/aprcm_div.sv]
// ----------------------------------------------------------------------------
// aprcm_div
// Pipelined restoring divider, two numerators over one shared divisor, one
// quotient bit per stage, with a sideband that travels along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aprcm_div #(
  parameter int C   = 12,
  parameter int PLW = 8
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [2*C-1:0] n0,
  input  wire logic [2*C-1:0] n1,
  input  wire logic [C-1:0]   d,
  input  wire logic [PLW-1:0] pl_in,
  output logic      [C-1:0]   q0,
  output logic      [C-1:0]   q1,
  output logic      [PLW-1:0] pl_out
);

  // one restoring step: remainder in the upper half, quotient shifts in below
  function automatic logic [2*C-1:0] div_step(input logic [2*C-1:0] s,
                                              input logic [C-1:0] dv);
    logic [C:0]   t;
    logic [C-1:0] rem;
    logic         qb;
    t   = {s[2*C-1:C], s[C-1]};
    qb  = (t >= {1'b0, dv});
    rem = qb ? C'(t - {1'b0, dv}) : t[C-1:0];
    return {rem, s[C-2:0], qb};
  endfunction

  logic [2*C-1:0] st0 [0:C];
  logic [2*C-1:0] st1 [0:C];
  logic [C-1:0]   dv  [0:C];
  logic [PLW-1:0] pl  [0:C];

  assign st0[0] = n0;
  assign st1[0] = n1;
  assign dv[0]  = d;
  assign pl[0]  = pl_in;

  // stage registers
  for (genvar k = 1; k <= C; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        st0[k] <= div_step(st0[k-1], dv[k-1]);
        st1[k] <= div_step(st1[k-1], dv[k-1]);
        dv[k]  <= dv[k-1];
        pl[k]  <= pl[k-1];
      end
    end
  end

  assign q0     = st0[C][C-1:0];
  assign q1     = st1[C][C-1:0];
  assign pl_out = pl[C];

endmodule

`default_nettype wire

[rtl/aprcm_axis.sv]
// ----------------------------------------------------------------------------
// aprcm_axis
// One axis of the clip and map: piece interval recovery, crop clamp,
// intersection with the request and scaling back into the piece.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aprcm_axis
  import aprcm_pkg::*;
#(
  parameter int C = 12
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [REQ_BITS-1:0] r0,
  input  wire logic signed [REQ_BITS-1:0] rl,
  input  wire logic        [C-1:0]        p,
  input  wire logic        [C-1:0]        pw,
  input  wire logic        [C-1:0]        c0,
  input  wire logic        [C-1:0]        cl,
  input  wire logic        [C-1:0]        al,
  output logic                            empty,
  output logic             [C:0]          s0,
  output logic             [C:0]          slen,
  output logic             [C-1:0]        a0,
  output logic             [C-1:0]        alen
);

  localparam int PL1 = 2 + 2 * SW;
  localparam int PL2 = 1 + 2 * (C + 1);

  // stage 1: piece offset from the crop origin
  logic signed [C:0]    off;
  logic signed [C+1:0]  off_end;
  logic        [C-1:0]  n0_1;
  logic        [C:0]    n1_1;
  logic signed [SW-1:0] r0_1, re_1;

  assign off     = $signed({1'b0, p}) - $signed({1'b0, c0});
  assign off_end = $signed({off[C], off}) + $signed({2'b00, pw});

  always_ff @(posedge clk) begin
    if (en) begin
      n0_1 <= off[C] ? '0 : off[C-1:0];
      n1_1 <= off_end[C+1] ? '0 : off_end[C:0];
      r0_1 <= SW'(r0);
      re_1 <= SW'(r0) + SW'(rl);
    end
  end

  // stage 2: scale by crop size, saturation limit
  logic        [2*C-1:0] prod0_2;
  logic        [2*C:0]   prod1_2;
  logic        [2*C:0]   lim_2;
  logic signed [SW-1:0]  r0_2, re_2;

  always_ff @(posedge clk) begin
    if (en) begin
      prod0_2 <= n0_1 * cl;
      prod1_2 <= n1_1 * cl;
      lim_2   <= ({1'b0, cl} + (C+1)'(1)) * al;
      r0_2    <= r0_1;
      re_2    <= re_1;
    end
  end

  // stage 3: quotients above the crop size saturate
  logic        [2*C-1:0] num0_3, num1_3;
  logic                  sat0_3, sat1_3;
  logic signed [SW-1:0]  r0_3, re_3;

  always_ff @(posedge clk) begin
    if (en) begin
      num0_3 <= prod0_2;
      num1_3 <= prod1_2[2*C-1:0];
      sat0_3 <= ({1'b0, prod0_2} >= lim_2);
      sat1_3 <= (prod1_2 >= lim_2);
      r0_3   <= r0_2;
      re_3   <= re_2;
    end
  end

  // divide by atlas size
  logic [C-1:0]   q0_d1, q1_d1;
  logic [PL1-1:0] pl1;

  aprcm_div #(.C(C), .PLW(PL1)) u_div_crop (
    .clk    (clk),
    .en     (en),
    .n0     (num0_3),
    .n1     (num1_3),
    .d      (al),
    .pl_in  ({sat0_3, sat1_3, r0_3, re_3}),
    .q0     (q0_d1),
    .q1     (q1_d1),
    .pl_out (pl1)
  );

  // stage e1: clamp offsets into the crop
  logic        [C-1:0]  k0_s, k1_s;
  logic        [C-1:0]  k0, k1;
  logic signed [SW-1:0] r0_e1, re_e1;

  assign k0_s = pl1[PL1-1] ? cl : q0_d1;
  assign k1_s = pl1[PL1-2] ? cl : q1_d1;

  always_ff @(posedge clk) begin
    if (en) begin
      k0    <= k0_s;
      k1    <= (k1_s > k0_s) ? k1_s : k0_s;
      r0_e1 <= pl1[2*SW-1:SW];
      re_e1 <= pl1[SW-1:0];
    end
  end

  // stage e2: intersect with the request
  logic signed [SW-1:0] px0, px1, sx0, sx1;
  logic                 emp_e2;
  logic        [C:0]    s0_e2, slen_e2;
  logic        [C-1:0]  dd_e2, d0_e2, d1_e2;

  assign px0 = SW'(c0) + SW'(k0);
  assign px1 = SW'(c0) + SW'(k1);
  assign sx0 = (r0_e1 > px0) ? r0_e1 : px0;
  assign sx1 = (re_e1 < px1) ? re_e1 : px1;

  always_ff @(posedge clk) begin
    if (en) begin
      emp_e2  <= (sx1 <= sx0);
      s0_e2   <= sx0[C:0];
      slen_e2 <= (C+1)'(sx1 - sx0);
      dd_e2   <= k1 - k0;
      d0_e2   <= C'(sx0 - px0);
      d1_e2   <= C'(sx1 - px0);
    end
  end

  // stage e3: scale by piece size
  logic [2*C-1:0] m0_e3, m1_e3;
  logic [C-1:0]   dd_e3;
  logic [PL2-1:0] pl_e3;

  always_ff @(posedge clk) begin
    if (en) begin
      m0_e3 <= d0_e2 * pw;
      m1_e3 <= d1_e2 * pw;
      dd_e3 <= dd_e2;
      pl_e3 <= {emp_e2, s0_e2, slen_e2};
    end
  end

  // divide by the clipped piece interval
  logic [C-1:0]   q0_d2, q1_d2;
  logic [PL2-1:0] pl2;

  aprcm_div #(.C(C), .PLW(PL2)) u_div_piece (
    .clk    (clk),
    .en     (en),
    .n0     (m0_e3),
    .n1     (m1_e3),
    .d      (dd_e3),
    .pl_in  (pl_e3),
    .q0     (q0_d2),
    .q1     (q1_d2),
    .pl_out (pl2)
  );

  // final register
  always_ff @(posedge clk) begin
    if (en) begin
      empty <= pl2[PL2-1];
      s0    <= pl2[2*C+1:C+1];
      slen  <= pl2[C:0];
      a0    <= q0_d2;
      alen  <= q1_d2 - q0_d2;
    end
  end

endmodule

`default_nettype wire

[rtl/atlas_piece_rect_clip_map.sv]
// ----------------------------------------------------------------------------
// atlas_piece_rect_clip_map
// Clips request rectangles against one atlas piece and maps them into it.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle while the pipeline advances and returns
// one result beat per request, in order. Each axis holds two pipelined
// restoring dividers, one quotient bit per stage: one recovers the piece
// interval in crop space, the other scales the clipped interval into the
// piece. The whole pipeline holds when the output beat is not taken.
// Configuration is read by the stages directly, so registers must be written
// only while no request is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module atlas_piece_rect_clip_map
  import aprcm_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request_x, request_y, request_w, request_h, 16 bits each
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [4*REQ_BITS-1:0]    s_tdata,
  // src_x, src_y, src_w, src_h, atlas_x, atlas_y, atlas_w, atlas_h
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [((8*COORD_BITS+4+7)/8)*8-1:0] m_tdata,
  // hit
  output logic                          m_tuser,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int C   = COORD_BITS;
  localparam int LAT = 2 * C + 7;
  localparam int TDW = ((8 * C + 4 + 7) / 8) * 8;

  // configuration registers
  logic [C-1:0]             piece_x, piece_y, piece_width, piece_height;
  logic [C-1:0]             crop_x, crop_y;
  logic [SIZE_REG_BITS-1:0] crop_size, atlas_size;
  reg_idx_t                 reg_idx;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      piece_x      <= '0;
      piece_y      <= '0;
      piece_width  <= '0;
      piece_height <= '0;
      crop_x       <= '0;
      crop_y       <= '0;
      crop_size    <= '0;
      atlas_size   <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_PIECE_X:      piece_x      <= pwdata[C-1:0];
        REG_PIECE_Y:      piece_y      <= pwdata[C-1:0];
        REG_PIECE_WIDTH:  piece_width  <= pwdata[C-1:0];
        REG_PIECE_HEIGHT: piece_height <= pwdata[C-1:0];
        REG_CROP_X:       crop_x       <= pwdata[C-1:0];
        REG_CROP_Y:       crop_y       <= pwdata[C-1:0];
        REG_CROP_SIZE:    crop_size    <= pwdata[SIZE_REG_BITS-1:0];
        REG_ATLAS_SIZE:   atlas_size   <= pwdata[SIZE_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_PIECE_X:      prdata = CFG_DATA_BITS'(piece_x);
      REG_PIECE_Y:      prdata = CFG_DATA_BITS'(piece_y);
      REG_PIECE_WIDTH:  prdata = CFG_DATA_BITS'(piece_width);
      REG_PIECE_HEIGHT: prdata = CFG_DATA_BITS'(piece_height);
      REG_CROP_X:       prdata = CFG_DATA_BITS'(crop_x);
      REG_CROP_Y:       prdata = CFG_DATA_BITS'(crop_y);
      REG_CROP_SIZE:    prdata = CFG_DATA_BITS'(crop_size);
      REG_ATLAS_SIZE:   prdata = CFG_DATA_BITS'(atlas_size);
      default:          prdata = '0;
    endcase
  end

  // size fields
  logic [C-1:0] crop_w, crop_h, atlas_w, atlas_h;

  assign crop_w  = crop_size[C-1:0];
  assign crop_h  = C'(crop_size >> C);
  assign atlas_w = atlas_size[C-1:0];
  assign atlas_h = C'(atlas_size >> C);

  // request fields
  logic signed [REQ_BITS-1:0] req_x, req_y, req_w, req_h;

  assign req_x = s_tdata[REQ_BITS-1:0];
  assign req_y = s_tdata[2*REQ_BITS-1:REQ_BITS];
  assign req_w = s_tdata[3*REQ_BITS-1:2*REQ_BITS];
  assign req_h = s_tdata[4*REQ_BITS-1:3*REQ_BITS];

  // pipeline advance, valid and reject bits
  logic           en;
  logic           rej_in;
  logic [LAT-1:0] vld, rej;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  assign rej_in = (req_w <= 0) || (req_h <= 0) || (piece_width == '0) ||
                  (piece_height == '0) || (crop_w == '0) || (crop_h == '0) ||
                  (atlas_w == '0) || (atlas_h == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rej <= {rej[LAT-2:0], rej_in};
    end
  end

  // per-axis datapaths
  logic         emp_x, emp_y;
  logic [C:0]   sx, sy, sw, sh;
  logic [C-1:0] ax, ay, aw, ah;

  aprcm_axis #(.C(C)) u_axis_x (
    .clk   (clk),
    .en    (en),
    .r0    (req_x),
    .rl    (req_w),
    .p     (piece_x),
    .pw    (piece_width),
    .c0    (crop_x),
    .cl    (crop_w),
    .al    (atlas_w),
    .empty (emp_x),
    .s0    (sx),
    .slen  (sw),
    .a0    (ax),
    .alen  (aw)
  );

  aprcm_axis #(.C(C)) u_axis_y (
    .clk   (clk),
    .en    (en),
    .r0    (req_y),
    .rl    (req_h),
    .p     (piece_y),
    .pw    (piece_height),
    .c0    (crop_y),
    .cl    (crop_h),
    .al    (atlas_h),
    .empty (emp_y),
    .s0    (sy),
    .slen  (sh),
    .a0    (ay),
    .alen  (ah)
  );

  // result assembly, zeroed for rejected or empty requests
  logic zero_out;

  assign zero_out = rej[LAT-1] || emp_x || emp_y;
  assign m_tuser  = !zero_out && (aw != '0) && (ah != '0);
  assign m_tdata  = zero_out ? '0 : TDW'({ah, aw, ay, ax, sh, sw, sy, sx});

endmodule

`default_nettype wire

[dv/aprcm_checker.sv]
// ----------------------------------------------------------------------------
// aprcm_checker
// Predicts and checks the result of every accepted request beat.
// ----------------------------------------------------------------------------
// It follows configuration writes on the register port and keeps its own copy
// of the piece geometry. On each accepted request it queues the expected
// result, and on each accepted result beat it compares field by field with
// the oldest entry in that queue.
`timescale 1ns / 1ps
`default_nettype none

module aprcm_checker
  import aprcm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  input  wire logic                     s_tready,
  input  wire logic [4*REQ_BITS-1:0]    s_tdata,
  input  wire logic                     m_tvalid,
  input  wire logic                     m_tready,
  input  wire logic [103:0]             m_tdata,
  input  wire logic                     m_tuser,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output int                            errors,
  output int                            pending
);

  typedef struct packed {
    logic        hit;
    logic [12:0] src_x, src_y, src_w, src_h;
    logic [11:0] atlas_x, atlas_y, atlas_w, atlas_h;
  } mapped_rect_t;

  // shadow of the piece geometry
  logic [11:0] pc_x, pc_y, pc_w, pc_h, cr_x, cr_y;
  logic [23:0] cr_size, at_size;

  mapped_rect_t rect_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // clip the request against the piece interval and map it into the piece
  function automatic mapped_rect_t map_request(logic [63:0] req);
    mapped_rect_t r;
    longint rx, ry, rw, rh, pw, ph, cx, cy, cw, ch, aw, ah;
    longint ox, oy, x0, y0, x1, y1, sx0, sy0, sx1, sy1, ax0, ay0, ax1, ay1;
    r = '0;
    rx = longint'($signed(req[15:0]));
    ry = longint'($signed(req[31:16]));
    rw = longint'($signed(req[47:32]));
    rh = longint'($signed(req[63:48]));
    pw = pc_w; ph = pc_h; cx = cr_x; cy = cr_y;
    cw = cr_size[11:0]; ch = cr_size[23:12];
    aw = at_size[11:0]; ah = at_size[23:12];
    if (rw <= 0 || rh <= 0 || pw == 0 || ph == 0 || cw == 0 || ch == 0 ||
        aw == 0 || ah == 0) return r;
    ox = longint'(pc_x) - cx;
    oy = longint'(pc_y) - cy;
    x0 = clip(cx + (ox * cw) / aw, cx, cx + cw);
    y0 = clip(cy + (oy * ch) / ah, cy, cy + ch);
    x1 = clip(cx + ((ox + pw) * cw) / aw, x0, cx + cw);
    y1 = clip(cy + ((oy + ph) * ch) / ah, y0, cy + ch);
    sx0 = (rx > x0) ? rx : x0;
    sy0 = (ry > y0) ? ry : y0;
    sx1 = (rx + rw < x1) ? rx + rw : x1;
    sy1 = (ry + rh < y1) ? ry + rh : y1;
    if (sx1 <= sx0 || sy1 <= sy0) return r;
    ax0 = clip(((sx0 - x0) * pw) / (x1 - x0), 0, pw);
    ay0 = clip(((sy0 - y0) * ph) / (y1 - y0), 0, ph);
    ax1 = clip(((sx1 - x0) * pw) / (x1 - x0), ax0, pw);
    ay1 = clip(((sy1 - y0) * ph) / (y1 - y0), ay0, ph);
    r.hit = (ax1 > ax0) && (ay1 > ay0);
    r.src_x = sx0[12:0];
    r.src_y = sy0[12:0];
    r.src_w = 13'(sx1 - sx0);
    r.src_h = 13'(sy1 - sy0);
    r.atlas_x = ax0[11:0];
    r.atlas_y = ay0[11:0];
    r.atlas_w = 12'(ax1 - ax0);
    r.atlas_h = 12'(ay1 - ay0);
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign pending = rect_q.size();

  // track register writes
  always @(posedge clk) begin
    if (rst) begin
      pc_x <= '0; pc_y <= '0; pc_w <= '0; pc_h <= '0;
      cr_x <= '0; cr_y <= '0; cr_size <= '0; at_size <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_PIECE_X:      pc_x <= pwdata[11:0];
        REG_PIECE_Y:      pc_y <= pwdata[11:0];
        REG_PIECE_WIDTH:  pc_w <= pwdata[11:0];
        REG_PIECE_HEIGHT: pc_h <= pwdata[11:0];
        REG_CROP_X:       cr_x <= pwdata[11:0];
        REG_CROP_Y:       cr_y <= pwdata[11:0];
        REG_CROP_SIZE:    cr_size <= pwdata[23:0];
        REG_ATLAS_SIZE:   at_size <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // predict on request beats, compare on result beats
  initial errors = 0;
  always @(posedge clk) begin
    mapped_rect_t e;
    if (!rst && s_tvalid && s_tready) rect_q.push_back(map_request(s_tdata));
    if (!rst && m_tvalid && m_tready) begin
      if (rect_q.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
      end else begin
        e = rect_q.pop_front();
        check_field("hit", e.hit, m_tuser);
        check_field("src_x", e.src_x, m_tdata[12:0]);
        check_field("src_y", e.src_y, m_tdata[25:13]);
        check_field("src_w", e.src_w, m_tdata[38:26]);
        check_field("src_h", e.src_h, m_tdata[51:39]);
        check_field("atlas_x", e.atlas_x, m_tdata[63:52]);
        check_field("atlas_y", e.atlas_y, m_tdata[75:64]);
        check_field("atlas_w", e.atlas_w, m_tdata[87:76]);
        check_field("atlas_h", e.atlas_h, m_tdata[99:88]);
      end
    end
  end

endmodule

`default_nettype wire

[dv/tb_atlas_piece_rect_clip_map.sv]
// ----------------------------------------------------------------------------
// tb_atlas_piece_rect_clip_map
// Stimulus and verdict for the atlas piece clip and map block.
// ----------------------------------------------------------------------------
// Writes several piece geometries, zero and full-scale ones among them, and
// sends directed then random request rectangles, most of them placed around
// the crop so that they clip into the piece. Sender gaps and receiver stalls
// vary by phase. The checker predicts and compares every result beat.
`timescale 1ns / 1ps
`default_nettype none

module tb_atlas_piece_rect_clip_map;
  import aprcm_pkg::*;

  localparam int PIPE_CYCLES = 40;
  localparam int STALL_LIMIT = 3000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [4*REQ_BITS-1:0]    s_tdata = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [103:0]             m_tdata;
  logic                     m_tuser;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  int errors, pending;
  int gap_pct = 0, stall_pct = 0;
  int idle_cycles = 0;
  // crop window of the current geometry, used to aim requests
  int win_x, win_y, win_w, win_h;

  always #5 clk = ~clk;

  atlas_piece_rect_clip_map dut (.*);

  aprcm_checker chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .psel, .penable, .pwrite, .paddr, .pwdata,
    .errors, .pending
  );

  // receiver back-pressure
  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= stall_pct);

  // watchdog on cycles with no beat accepted
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= CFG_ADDR_BITS'(4 * int'(idx)); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drain the pipeline before touching the registers
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(int px, int py, int pw, int ph, int cx, int cy,
                              int cw, int ch, int aw, int ah);
    wait_drained();
    reg_write(REG_PIECE_X, px);
    reg_write(REG_PIECE_Y, py);
    reg_write(REG_PIECE_WIDTH, pw);
    reg_write(REG_PIECE_HEIGHT, ph);
    reg_write(REG_CROP_X, cx);
    reg_write(REG_CROP_Y, cy);
    reg_write(REG_CROP_SIZE, 32'({ch[11:0], cw[11:0]}));
    reg_write(REG_ATLAS_SIZE, 32'({ah[11:0], aw[11:0]}));
    win_x = cx; win_y = cy; win_w = cw; win_h = ch;
  endtask

  // one request beat, entered and left at a falling edge
  task automatic send_rect(int rx, int ry, int rw, int rh);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {rh[15:0], rw[15:0], ry[15:0], rx[15:0]};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_random_rect();
    int rx, ry, rw, rh;
    if ($urandom_range(0, 99) < 80) begin
      rx = win_x + $urandom_range(0, win_w + 40) - 20;
      ry = win_y + $urandom_range(0, win_h + 40) - 20;
      rw = $urandom_range(1, win_w + 40);
      rh = $urandom_range(1, win_h + 40);
    end else begin
      rx = $urandom; ry = $urandom; rw = $urandom; rh = $urandom;
    end
    send_rect(rx, ry, rw, rh);
  endtask

  task automatic random_geometry();
    int cx, cy, cw, ch, aw, ah;
    cx = $urandom_range(0, 300); cy = $urandom_range(0, 300);
    cw = $urandom_range(1, 400); ch = $urandom_range(1, 400);
    aw = $urandom_range(1, 400); ah = $urandom_range(1, 400);
    set_geometry($urandom_range(0, aw + 40), $urandom_range(0, ah + 40),
                 $urandom_range(1, 200), $urandom_range(1, 200),
                 cx, cy, cw, ch, aw, ah);
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at reset: every request is rejected
    win_x = 0; win_y = 0; win_w = 100; win_h = 100;
    send_rect(0, 0, 10, 10);
    send_rect(-32768, 32767, 32767, 32767);

    // ordinary geometry
    set_geometry(100, 50, 64, 32, 80, 40, 200, 120, 300, 180);
    send_rect(80, 40, 200, 120);
    send_rect(90, 45, 0, 10);
    send_rect(90, 45, 10, -1);
    send_rect(-32768, -32768, 32767, 32767);
    send_rect(32767, 32767, 32767, 32767);
    send_rect(-32768, -32768, -32768, -32768);
    send_rect(0, 0, 5, 5);
    send_rect(150, 70, 1, 1);
    send_rect(140, 60, 20, 10);

    // piece before the crop origin, one atlas pixel wide: degenerate maps
    set_geometry(10, 5, 1, 1, 30, 20, 400, 300, 40, 30);
    send_rect(30, 20, 400, 300);
    send_rect(35, 25, 3, 3);
    send_rect(29, 19, 2, 2);

    // single zero size registers reject
    set_geometry(5, 5, 0, 10, 0, 0, 50, 50, 50, 50);
    send_rect(0, 0, 50, 50);
    set_geometry(5, 5, 10, 10, 0, 0, 50, 50, 50, 0);
    send_rect(0, 0, 50, 50);

    // full-scale registers
    set_geometry(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    send_rect(4095, 4095, 4095, 4095);
    send_rect(5000, 5000, 32767, 32767);
    set_geometry(4095, 4095, 4095, 4095, 0, 0, 4095, 4095, 1, 1);
    send_rect(0, 0, 8191, 8191);
    set_geometry(0, 0, 4095, 4095, 0, 0, 4095, 4095, 4095, 4095);
    send_rect(0, 0, 4095, 4095);
    send_rect(1000, 2000, 7, 9);

    // random phases with varying gaps and stalls
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 4)
        set_geometry(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
      else
        random_geometry();
      gap_pct = (phase % 4 == 1) ? 59 : (phase % 4 == 3) ? 38 : 0;
      stall_pct = (phase % 4 == 2) ? 59 : (phase % 4 == 3) ? 38 : 0;
      repeat (90) begin
        send_random_rect();
        if (phase == 2 && $urandom_range(0, 29) == 0) begin
          s_tvalid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
    end

    s_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/aprcm_pkg.sv
rtl/aprcm_div.sv
rtl/aprcm_axis.sv
rtl/atlas_piece_rect_clip_map.sv
dv/aprcm_checker.sv
dv/tb_atlas_piece_rect_clip_map.sv
